/* hdl/encrypted_blob_header_parser_unit_macros.svh */
// Assertion shorthands for the header parser; clk and rst_n come from the using module.
`ifndef ENCRYPTED_BLOB_HEADER_PARSER_UNIT_MACROS_SVH
`define ENCRYPTED_BLOB_HEADER_PARSER_UNIT_MACROS_SVH

// Check in the same cycle.
`define EBHP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ebhp same-cycle check failed");

// Check in the next cycle.
`define EBHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ebhp next-cycle check failed");

`endif

/* hdl/ebhp_pkg.sv */
`timescale 1ns / 1ps

package ebhp_pkg;

  localparam int NONCE_MAX  = 16;
  localparam int HASH_CHARS = 64;
  localparam int META_CAP   = 4096;
  localparam int KEY_LEN    = 21;
  localparam int WIN_LEN    = KEY_LEN - 1;
  localparam int CLEN_BYTES = 8;
  localparam int QDEPTH     = 4;
  localparam int POS_MAX    = 8191;

  typedef logic [7:0] byte_t;

  localparam byte_t MODE_GCM = 8'h01;

  localparam byte_t MAGIC [4] = '{"C", "P", "F", "E"};

  localparam byte_t HASH_KEY [KEY_LEN] = '{
    8'h22, "p", "l", "a", "i", "n", "t", "e", "x", "t", "_",
    "s", "h", "a", "2", "5", "6", 8'h22, ":", " ", 8'h22
  };

  typedef enum logic [7:0] {
    PH_FIXED = 8'b0000_0001,
    PH_LEN   = 8'b0000_0010,
    PH_META  = 8'b0000_0100,
    PH_NLEN  = 8'b0000_1000,
    PH_NONCE = 8'b0001_0000,
    PH_TLEN  = 8'b0010_0000,
    PH_TAG   = 8'b0100_0000,
    PH_CLEN  = 8'b1000_0000
  } phase_t;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_NONCE = 2'd0;
  localparam kind_t KIND_HASH  = 2'd1;
  localparam kind_t KIND_FIN   = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_SHORT    = 3'd1;
  localparam status_t ST_MAGIC    = 3'd2;
  localparam status_t ST_META     = 3'd3;
  localparam status_t ST_NONCE    = 3'd4;
  localparam status_t ST_TRUNC    = 3'd5;

  typedef struct packed {
    kind_t       kind;
    byte_t       value;
    logic [5:0]  item_index;
    status_t     status;
    logic [12:0] header_length;
    logic [31:0] metadata_length;
    byte_t       mode;
    logic        hash_found;
    logic        run_end;
  } res_t;

  function automatic res_t mk_res(kind_t k, byte_t v, logic [5:0] idx, status_t st,
                                  logic [12:0] hdr, logic [31:0] meta, byte_t md,
                                  logic found);
    res_t r;
    r.kind            = k;
    r.value           = v;
    r.item_index      = idx;
    r.status          = st;
    r.header_length   = hdr;
    r.metadata_length = meta;
    r.mode            = md;
    r.hash_found      = found;
    r.run_end         = 1'b0;
    return r;
  endfunction

endpackage

/* hdl/ebhp_win_cell.sv */
`timescale 1ns / 1ps

module ebhp_win_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  input  logic          shift,
  input  ebhp_pkg::byte_t din,
  input  ebhp_pkg::byte_t key_char,
  output ebhp_pkg::byte_t q,
  output logic          hit
);

  ebhp_pkg::byte_t q_r;
  ebhp_pkg::byte_t q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (clr) begin
      q_nxt = '0;
    end else if (shift) begin
      q_nxt = din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q   = q_r;
  assign hit = (q_r == key_char);

endmodule

/* hdl/ebhp_res_queue.sv */
`timescale 1ns / 1ps

module ebhp_res_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     push_cnt,
  input  ebhp_pkg::res_t push_data [3],
  input  logic           pop,
  output ebhp_pkg::res_t head,
  output logic           not_empty,
  output logic           room3
);

  localparam int PW = $clog2(ebhp_pkg::QDEPTH);
  localparam int CW = $clog2(ebhp_pkg::QDEPTH + 1);

  ebhp_pkg::res_t mem_r [ebhp_pkg::QDEPTH];
  logic [PW-1:0]  wr_r, wr_nxt;
  logic [PW-1:0]  rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_pop;

  assign do_pop    = pop && (cnt_r != '0);
  assign not_empty = (cnt_r != '0);
  assign room3     = (cnt_r <= CW'(ebhp_pkg::QDEPTH - 3));
  assign head      = mem_r[rd_r];

  always_comb begin
    wr_nxt  = PW'(wr_r + PW'(push_cnt));
    rd_nxt  = do_pop ? PW'(rd_r + PW'(1)) : rd_r;
    cnt_nxt = CW'(cnt_r + CW'(push_cnt) - CW'(do_pop));
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_cnt) begin
        mem_r[PW'(wr_r + PW'(i))] <= push_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* hdl/encrypted_blob_header_parser_unit.sv */
// Container header parser, one byte per input word.
// Input channel: in_data_byte with in_last_byte on the final byte of a buffer,
// moved by in_valid/in_ready. Result channel: out_* fields moved by
// out_valid/out_ready; a byte yields zero to three result words (nonce byte,
// hash character, finish), the last one flagged by out_run_end.
// Configuration: APB register 0 at address 0, max_metadata_len (13 bits).
// Results: a byte's result words are written to the result queue as the byte is taken and are offered from its head.
// Throughput: one byte per cycle while each byte yields at most one result word
// and the receiver keeps up; the four-word result queue takes a byte only
// when three words are free, so bytes yielding two or three words hold the
// input until the receiver drains them. The key search is a row of 20 byte
// cells that shift once per metadata byte and compare in place.
// Reset: parse state clears, the limit returns to 4096, the queue empties.
// When the receiver stalls, results wait in the queue and in_ready drops once
// fewer than three slots are free; nothing is dropped.
// A byte with in_last_byte set restarts the parse for the next buffer.
`timescale 1ns / 1ps
`include "encrypted_blob_header_parser_unit_macros.svh"

module encrypted_blob_header_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_value,
  output logic [5:0]  out_item_index,
  output logic [2:0]  out_status,
  output logic [12:0] out_header_length,
  output logic [31:0] out_metadata_length,
  output logic [7:0]  out_mode,
  output logic        out_hash_found,
  output logic        out_run_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [12:0]       max_len_r, max_len_nxt;
  logic [12:0]       pos_r, pos_nxt;
  ebhp_pkg::phase_t  phase_r, phase_nxt;
  logic              magic_r, magic_nxt;
  ebhp_pkg::byte_t   mode_r, mode_nxt;
  logic [31:0]       meta_r, meta_nxt;
  logic [12:0]       rem_r, rem_nxt;
  logic              stop_r, stop_nxt;
  logic [6:0]        taken_r, taken_nxt;
  logic              fin_sent_r, fin_sent_nxt;

  logic              in_fire;
  logic              room3;
  logic              q_not_empty;
  ebhp_pkg::res_t    q_head;
  ebhp_pkg::res_t    res [3];
  logic [1:0]        res_cnt;

  logic              win_clr;
  logic              win_shift;
  logic              win_match;
  ebhp_pkg::byte_t   win_q [ebhp_pkg::WIN_LEN];
  logic [ebhp_pkg::WIN_LEN-1:0] win_hit;

  logic              fin;
  ebhp_pkg::status_t status;
  logic [12:0]       hdr;
  logic              nonce_out;
  logic              hash_out;
  logic [5:0]        nonce_idx;
  logic [5:0]        hash_idx;
  logic [12:0]       rem_dec;
  logic [12:0]       limit;
  logic [31:0]       meta_tmp;

  assign pready   = 1'b1;
  assign prdata   = {19'b0, max_len_r};
  assign in_ready = room3;
  assign in_fire  = in_valid && room3;

  always_comb begin
    max_len_nxt = max_len_r;
    if (psel && penable && pwrite) begin
      max_len_nxt = pwdata[12:0];
    end
  end

  for (genvar i = 0; i < ebhp_pkg::WIN_LEN; i++) begin : g_win
    ebhp_pkg::byte_t din;
    if (i == ebhp_pkg::WIN_LEN - 1) begin : g_tail
      assign din = in_data_byte;
    end else begin : g_body
      assign din = win_q[i+1];
    end
    ebhp_win_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clr      (win_clr),
      .shift    (win_shift),
      .din      (din),
      .key_char (ebhp_pkg::HASH_KEY[i]),
      .q        (win_q[i]),
      .hit      (win_hit[i])
    );
  end

  assign win_match = (&win_hit) && (in_data_byte == ebhp_pkg::HASH_KEY[ebhp_pkg::KEY_LEN-1]);
  assign limit     = (max_len_r < 13'(ebhp_pkg::META_CAP)) ? max_len_r
                                                           : 13'(ebhp_pkg::META_CAP);
  assign rem_dec   = 13'(rem_r - 13'd1);

  always_comb begin
    case (rem_r[1:0])
      2'd0:    meta_tmp = meta_r | {24'b0, in_data_byte};
      2'd3:    meta_tmp = meta_r | {16'b0, in_data_byte, 8'b0};
      2'd2:    meta_tmp = meta_r | {8'b0, in_data_byte, 16'b0};
      default: meta_tmp = meta_r | {in_data_byte, 24'b0};
    endcase
  end

  always_comb begin
    pos_nxt      = pos_r;
    phase_nxt    = phase_r;
    magic_nxt    = magic_r;
    mode_nxt     = mode_r;
    meta_nxt     = meta_r;
    rem_nxt      = rem_r;
    stop_nxt     = stop_r;
    taken_nxt    = taken_r;
    fin_sent_nxt = fin_sent_r;
    fin          = 1'b0;
    status       = ebhp_pkg::ST_OK;
    hdr          = '0;
    nonce_out    = 1'b0;
    hash_out     = 1'b0;
    nonce_idx    = '0;
    hash_idx     = '0;
    win_shift    = 1'b0;
    win_clr      = 1'b0;
    res_cnt      = '0;
    for (int k = 0; k < 3; k++) begin
      res[k] = '0;
    end

    if (in_fire && !fin_sent_r) begin
      if (taken_r != '0 && taken_r <= 7'(ebhp_pkg::HASH_CHARS)) begin
        hash_out  = 1'b1;
        hash_idx  = 6'(taken_r - 7'd1);
        taken_nxt = 7'(taken_r + 7'd1);
      end

      unique case (phase_r)
        ebhp_pkg::PH_FIXED: begin
          if (pos_r < 13'd4 && in_data_byte != ebhp_pkg::MAGIC[pos_r[1:0]]) begin
            magic_nxt = 1'b0;
          end
          if (pos_r == 13'd6) begin
            mode_nxt = in_data_byte;
          end
          if (pos_r == 13'd7) begin
            if (!magic_r) begin
              fin    = 1'b1;
              status = ebhp_pkg::ST_MAGIC;
            end else begin
              phase_nxt = ebhp_pkg::PH_LEN;
              rem_nxt   = 13'd4;
            end
          end
        end
        ebhp_pkg::PH_LEN: begin
          meta_nxt = meta_tmp;
          rem_nxt  = rem_dec;
          if (rem_dec == '0) begin
            if (meta_tmp > {19'b0, limit}) begin
              fin    = 1'b1;
              status = ebhp_pkg::ST_META;
            end else begin
              win_clr = 1'b1;
              if (meta_tmp == '0) begin
                phase_nxt = ebhp_pkg::PH_NLEN;
              end else begin
                phase_nxt = ebhp_pkg::PH_META;
                rem_nxt   = meta_tmp[12:0];
              end
            end
          end
        end
        ebhp_pkg::PH_META: begin
          if (taken_r == '0 && !stop_r) begin
            if (in_data_byte == '0) begin
              stop_nxt = 1'b1;
            end else if (win_match) begin
              taken_nxt = 7'd1;
            end
          end
          win_shift = 1'b1;
          rem_nxt   = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = ebhp_pkg::PH_NLEN;
          end
        end
        ebhp_pkg::PH_NLEN: begin
          if (in_data_byte > 8'(ebhp_pkg::NONCE_MAX)) begin
            fin    = 1'b1;
            status = ebhp_pkg::ST_NONCE;
          end else if (in_data_byte == '0) begin
            if (mode_r == ebhp_pkg::MODE_GCM) begin
              phase_nxt = ebhp_pkg::PH_TLEN;
            end else begin
              phase_nxt = ebhp_pkg::PH_CLEN;
              rem_nxt   = 13'(ebhp_pkg::CLEN_BYTES);
            end
          end else begin
            phase_nxt = ebhp_pkg::PH_NONCE;
            rem_nxt   = {5'b0, in_data_byte};
          end
        end
        ebhp_pkg::PH_NONCE: begin
          nonce_out = 1'b1;
          nonce_idx = 6'(pos_r[5:0] - 6'd13 - meta_r[5:0]);
          rem_nxt   = rem_dec;
          if (rem_dec == '0) begin
            if (mode_r == ebhp_pkg::MODE_GCM) begin
              phase_nxt = ebhp_pkg::PH_TLEN;
            end else begin
              phase_nxt = ebhp_pkg::PH_CLEN;
              rem_nxt   = 13'(ebhp_pkg::CLEN_BYTES);
            end
          end
        end
        ebhp_pkg::PH_TLEN: begin
          if (in_data_byte == '0) begin
            phase_nxt = ebhp_pkg::PH_CLEN;
            rem_nxt   = 13'(ebhp_pkg::CLEN_BYTES);
          end else begin
            phase_nxt = ebhp_pkg::PH_TAG;
            rem_nxt   = {5'b0, in_data_byte};
          end
        end
        ebhp_pkg::PH_TAG: begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = ebhp_pkg::PH_CLEN;
            rem_nxt   = 13'(ebhp_pkg::CLEN_BYTES);
          end
        end
        ebhp_pkg::PH_CLEN: begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            fin    = 1'b1;
            status = ebhp_pkg::ST_OK;
            hdr    = 13'(pos_r + 13'd1);
          end
        end
        default: begin
        end
      endcase

      if (!fin && in_last_byte) begin
        fin = 1'b1;
        case (phase_nxt)
          ebhp_pkg::PH_FIXED: status = ebhp_pkg::ST_SHORT;
          ebhp_pkg::PH_META:  status = ebhp_pkg::ST_META;
          ebhp_pkg::PH_NONCE: status = ebhp_pkg::ST_NONCE;
          default:            status = ebhp_pkg::ST_TRUNC;
        endcase
      end

      pos_nxt = (pos_r < 13'(ebhp_pkg::POS_MAX)) ? 13'(pos_r + 13'd1) : pos_r;
      if (fin) begin
        fin_sent_nxt = 1'b1;
      end

      if (nonce_out) begin
        res[res_cnt] = ebhp_pkg::mk_res(ebhp_pkg::KIND_NONCE, in_data_byte, nonce_idx,
                                        ebhp_pkg::ST_OK, '0, meta_nxt, mode_nxt,
                                        taken_nxt != '0);
        res_cnt = 2'(res_cnt + 2'd1);
      end
      if (hash_out) begin
        res[res_cnt] = ebhp_pkg::mk_res(ebhp_pkg::KIND_HASH, in_data_byte, hash_idx,
                                        ebhp_pkg::ST_OK, '0, meta_nxt, mode_nxt,
                                        taken_nxt != '0);
        res_cnt = 2'(res_cnt + 2'd1);
      end
      if (fin) begin
        res[res_cnt] = ebhp_pkg::mk_res(ebhp_pkg::KIND_FIN, '0, '0, status,
                                        (status == ebhp_pkg::ST_OK) ? hdr : 13'd0,
                                        meta_nxt, mode_nxt, taken_nxt != '0);
        res_cnt = 2'(res_cnt + 2'd1);
      end
      if (res_cnt != '0) begin
        res[2'(res_cnt - 2'd1)].run_end = 1'b1;
      end
    end

    if (in_fire && in_last_byte) begin
      pos_nxt      = '0;
      phase_nxt    = ebhp_pkg::PH_FIXED;
      magic_nxt    = 1'b1;
      mode_nxt     = '0;
      meta_nxt     = '0;
      rem_nxt      = '0;
      stop_nxt     = 1'b0;
      taken_nxt    = '0;
      fin_sent_nxt = 1'b0;
      win_clr      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= 13'(ebhp_pkg::META_CAP);
      pos_r      <= '0;
      phase_r    <= ebhp_pkg::PH_FIXED;
      magic_r    <= 1'b1;
      mode_r     <= '0;
      meta_r     <= '0;
      rem_r      <= '0;
      stop_r     <= 1'b0;
      taken_r    <= '0;
      fin_sent_r <= 1'b0;
    end else begin
      max_len_r  <= max_len_nxt;
      pos_r      <= pos_nxt;
      phase_r    <= phase_nxt;
      magic_r    <= magic_nxt;
      mode_r     <= mode_nxt;
      meta_r     <= meta_nxt;
      rem_r      <= rem_nxt;
      stop_r     <= stop_nxt;
      taken_r    <= taken_nxt;
      fin_sent_r <= fin_sent_nxt;
    end
  end

  ebhp_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (res_cnt),
    .push_data (res),
    .pop       (out_ready),
    .head      (q_head),
    .not_empty (q_not_empty),
    .room3     (room3)
  );

  assign out_valid           = q_not_empty;
  assign out_kind            = q_head.kind;
  assign out_value           = q_head.value;
  assign out_item_index      = q_head.item_index;
  assign out_status          = q_head.status;
  assign out_header_length   = q_head.header_length;
  assign out_metadata_length = q_head.metadata_length;
  assign out_mode            = q_head.mode;
  assign out_hash_found      = q_head.hash_found;
  assign out_run_end         = q_head.run_end;

  `EBHP_ASSERT_NEXT(a_restart_on_last, in_valid && in_ready && in_last_byte, pos_r == '0 && phase_r == ebhp_pkg::PH_FIXED && !fin_sent_r)
  `EBHP_ASSERT_NOW(a_hash_word_found, out_valid && out_kind == ebhp_pkg::KIND_HASH, out_hash_found)
  `EBHP_ASSERT_NOW(a_data_word_no_status, out_valid && out_kind != ebhp_pkg::KIND_FIN, out_status == ebhp_pkg::ST_OK && out_header_length == '0)
  `EBHP_ASSERT_NEXT(a_finish_sticky, fin_sent_r && !(in_valid && in_ready && in_last_byte), fin_sent_r)

endmodule

/* bench/encrypted_blob_header_parser_unit_tb.sv */
`timescale 1ns / 1ps

module encrypted_blob_header_parser_unit_tb;
  import ebhp_pkg::*;

  localparam logic [1:0] ADDR_MAX_META = 2'd0;
  localparam int CYCLE_LIMIT = 200_000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_value;
  logic [5:0]  out_item_index;
  logic [2:0]  out_status;
  logic [12:0] out_header_length;
  logic [31:0] out_metadata_length;
  logic [7:0]  out_mode;
  logic        out_hash_found;
  logic        out_run_end;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  encrypted_blob_header_parser_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_value           (out_value),
    .out_item_index      (out_item_index),
    .out_status          (out_status),
    .out_header_length   (out_header_length),
    .out_metadata_length (out_metadata_length),
    .out_mode            (out_mode),
    .out_hash_found      (out_hash_found),
    .out_run_end         (out_run_end),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // parser mirror
  logic [12:0] meta_limit;
  logic [12:0] buf_pos;
  phase_t      parse_ph;
  logic        magic_good;
  byte_t       mode_q;
  logic [31:0] meta_len;
  int          remain;
  byte_t       key_window [WIN_LEN];
  logic        search_off;
  int          hash_taken;
  logic        finished;

  res_t  header_results_q [$];
  res_t  want;
  byte_t frame [$];
  int    errors;
  int    bytes_sent;
  int    cycles;
  bit    quiet;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= 34);
  end

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (header_results_q.size() == 0) begin
        $error("result word with nothing pending: kind %0d status %0d", out_kind, out_status);
        errors++;
      end else begin
        want = header_results_q.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("value", want.value, out_value);
        check_field("item_index", want.item_index, out_item_index);
        check_field("status", want.status, out_status);
        check_field("header_length", want.header_length, out_header_length);
        check_field("metadata_length", want.metadata_length, out_metadata_length);
        check_field("mode", want.mode, out_mode);
        check_field("hash_found", want.hash_found, out_hash_found);
        check_field("run_end", want.run_end, out_run_end);
      end
    end
  end

  function automatic void clear_parse();
    buf_pos    = '0;
    parse_ph   = PH_FIXED;
    magic_good = 1'b1;
    mode_q     = '0;
    meta_len   = '0;
    remain     = 0;
    for (int i = 0; i < WIN_LEN; i++) key_window[i] = '0;
    search_off = 1'b0;
    hash_taken = 0;
    finished   = 1'b0;
  endfunction

  function automatic res_t header_word(kind_t k, byte_t v, logic [5:0] idx, status_t st,
                                       logic [12:0] hdr);
    res_t r;
    r.kind            = k;
    r.value           = v;
    r.item_index      = idx;
    r.status          = st;
    r.header_length   = hdr;
    r.metadata_length = meta_len;
    r.mode            = mode_q;
    r.hash_found      = (hash_taken != 0);
    r.run_end         = 1'b0;
    return r;
  endfunction

  function automatic void leave_nonce();
    if (mode_q == MODE_GCM) begin
      parse_ph = PH_TLEN;
    end else begin
      parse_ph = PH_CLEN;
      remain   = CLEN_BYTES;
    end
  endfunction

  function automatic void predict_header(byte_t b, logic last);
    logic [12:0] p;
    logic [12:0] lim;
    logic [12:0] hdr;
    logic        fin;
    logic        nonce_hit;
    logic        hash_hit;
    logic        match;
    status_t     st;
    logic [5:0]  nonce_idx;
    logic [5:0]  hash_idx;
    res_t        step_q [3];
    int          n;
    if (!finished) begin
      p         = buf_pos;
      fin       = 1'b0;
      st        = ST_OK;
      hdr       = '0;
      nonce_hit = 1'b0;
      hash_hit  = 1'b0;
      nonce_idx = '0;
      hash_idx  = '0;
      n         = 0;
      lim       = (meta_limit < META_CAP) ? meta_limit : 13'(META_CAP);
      if (hash_taken != 0 && hash_taken - 1 < HASH_CHARS) begin
        hash_hit   = 1'b1;
        hash_idx   = 6'(hash_taken - 1);
        hash_taken = hash_taken + 1;
      end
      case (parse_ph)
        PH_FIXED: begin
          if (p < 4 && b != MAGIC[p]) magic_good = 1'b0;
          if (p == 6) mode_q = b;
          if (p == 7) begin
            if (!magic_good) begin
              fin = 1'b1;
              st  = ST_MAGIC;
            end else begin
              parse_ph = PH_LEN;
              remain   = 4;
            end
          end
        end
        PH_LEN: begin
          meta_len = meta_len | (32'(b) << (8 * (4 - remain)));
          remain   = remain - 1;
          if (remain == 0) begin
            if (meta_len > 32'(lim)) begin
              fin = 1'b1;
              st  = ST_META;
            end else begin
              for (int i = 0; i < WIN_LEN; i++) key_window[i] = '0;
              if (meta_len == 0) begin
                parse_ph = PH_NLEN;
              end else begin
                parse_ph = PH_META;
                remain   = int'(meta_len);
              end
            end
          end
        end
        PH_META: begin
          if (hash_taken == 0 && !search_off) begin
            if (b == 8'h00) begin
              search_off = 1'b1;
            end else if (b == HASH_KEY[KEY_LEN-1]) begin
              match = 1'b1;
              for (int i = 0; i < WIN_LEN; i++)
                if (key_window[i] != HASH_KEY[i]) match = 1'b0;
              if (match) hash_taken = 1;
            end
          end
          for (int i = 0; i < WIN_LEN - 1; i++) key_window[i] = key_window[i+1];
          key_window[WIN_LEN-1] = b;
          remain = remain - 1;
          if (remain == 0) parse_ph = PH_NLEN;
        end
        PH_NLEN: begin
          if (b > NONCE_MAX) begin
            fin = 1'b1;
            st  = ST_NONCE;
          end else if (b == 8'h00) begin
            leave_nonce();
          end else begin
            parse_ph = PH_NONCE;
            remain   = int'(b);
          end
        end
        PH_NONCE: begin
          nonce_hit = 1'b1;
          nonce_idx = 6'(32'(p) - 32'd13 - meta_len);
          remain    = remain - 1;
          if (remain == 0) leave_nonce();
        end
        PH_TLEN: begin
          if (b == 8'h00) begin
            parse_ph = PH_CLEN;
            remain   = CLEN_BYTES;
          end else begin
            parse_ph = PH_TAG;
            remain   = int'(b);
          end
        end
        PH_TAG: begin
          remain = remain - 1;
          if (remain == 0) begin
            parse_ph = PH_CLEN;
            remain   = CLEN_BYTES;
          end
        end
        default: begin
          remain = remain - 1;
          if (remain == 0) begin
            fin = 1'b1;
            st  = ST_OK;
            hdr = p + 13'd1;
          end
        end
      endcase
      if (!fin && last) begin
        fin = 1'b1;
        case (parse_ph)
          PH_FIXED: st = ST_SHORT;
          PH_META:  st = ST_META;
          PH_NONCE: st = ST_NONCE;
          default:  st = ST_TRUNC;
        endcase
      end
      buf_pos = (p < POS_MAX) ? p + 13'd1 : 13'(POS_MAX);
      if (nonce_hit) step_q[n++] = header_word(KIND_NONCE, b, nonce_idx, ST_OK, '0);
      if (hash_hit) step_q[n++] = header_word(KIND_HASH, b, hash_idx, ST_OK, '0);
      if (fin) begin
        step_q[n++] = header_word(KIND_FIN, '0, '0, st, (st == ST_OK) ? hdr : 13'd0);
        finished = 1'b1;
      end
      if (n > 0) step_q[n-1].run_end = 1'b1;
      for (int i = 0; i < n; i++) header_results_q.push_back(step_q[i]);
    end
    if (last) clear_parse();
  endfunction

  // call at a falling edge; returns at the falling edge after the byte is taken
  task automatic send_word(input byte_t b, input logic last);
    if (!quiet && $urandom_range(0, 99) < 34) repeat ($urandom_range(1, 2)) @(negedge clk);
    in_valid     = 1'b1;
    in_data_byte = b;
    in_last_byte = last;
    do @(posedge clk); while (!in_ready);
    predict_header(b, last);
    bytes_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic settle();
    while (header_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [12:0] v);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = ADDR_MAX_META;
    pwdata  = {19'($urandom), v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    meta_limit = v;
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    check_field("max_metadata_len", v, prdata[12:0]);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic build_frame(input byte_t md, input logic [31:0] len_field, input int key_at,
                             input int nonce_n, input int tag_n);
    int meta_n;
    meta_n = (len_field <= 32'd5000) ? int'(len_field) : 0;
    frame.delete();
    for (int i = 0; i < 4; i++) frame.push_back(MAGIC[i]);
    frame.push_back(byte_t'($urandom));
    frame.push_back(byte_t'($urandom));
    frame.push_back(md);
    frame.push_back(byte_t'($urandom));
    for (int i = 0; i < 4; i++) frame.push_back(len_field[8*i +: 8]);
    for (int i = 0; i < meta_n; i++) begin
      if (key_at >= 0 && i >= key_at && i < key_at + KEY_LEN) begin
        frame.push_back(HASH_KEY[i - key_at]);
      end else begin
        frame.push_back(byte_t'($urandom_range(1, 255)));
      end
    end
    frame.push_back(byte_t'(nonce_n));
    repeat (nonce_n) frame.push_back(byte_t'($urandom));
    if (md == MODE_GCM) begin
      frame.push_back(byte_t'(tag_n));
      repeat (tag_n) frame.push_back(byte_t'($urandom));
    end
    repeat (CLEN_BYTES) frame.push_back(byte_t'($urandom));
  endtask

  // cut = 0 sends the whole frame; pause_at < 0 never holds
  task automatic send_frame(input int cut, input int pause_at);
    int n;
    n = (cut > 0 && cut < frame.size()) ? cut : frame.size();
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) settle();
      send_word(frame[i], i == n - 1);
    end
  endtask

  task automatic test_short_and_magic();
    build_frame(MODE_GCM, 0, -1, 0, 0);
    send_frame(3, -1);
    build_frame(MODE_GCM, 0, -1, 0, 0);
    frame[0] = 8'h00;
    send_frame(5, -1);
    build_frame(MODE_GCM, 0, -1, 0, 0);
    frame[3] = 8'hFF;
    send_frame(0, -1);
    build_frame(MODE_GCM, 0, -1, 0, 0);
    send_frame(8, -1);
    build_frame(8'h00, 0, -1, 0, 0);
    send_frame(0, -1);
  endtask

  task automatic test_metadata_limit();
    build_frame(MODE_GCM, 32'd4097, -1, 0, 0);
    send_frame(14, -1);
    build_frame(MODE_GCM, 32'd4096, -1, 0, 0);
    send_frame(40, -1);
    build_frame(MODE_GCM, 32'hFFFF_FFFF, -1, 0, 0);
    send_frame(0, -1);
    settle();
    write_limit(13'h1FFF);
    build_frame(MODE_GCM, 32'd4097, -1, 0, 0);
    send_frame(14, -1);
    settle();
    write_limit(13'd0);
    build_frame(MODE_GCM, 32'd0, -1, 3, 2);
    send_frame(0, -1);
    build_frame(MODE_GCM, 32'd1, -1, 3, 2);
    send_frame(15, -1);
    settle();
    write_limit(13'd5);
    build_frame(8'h07, 32'd5, -1, 2, 0);
    send_frame(0, -1);
    settle();
    write_limit(13'(META_CAP));
  endtask

  task automatic test_nonce_and_tag();
    build_frame(MODE_GCM, 32'd2, -1, NONCE_MAX + 1, 0);
    send_frame(18, -1);
    build_frame(MODE_GCM, 32'd0, -1, NONCE_MAX, 255);
    send_frame(0, -1);
    build_frame(8'h02, 32'd1, -1, 5, 9);
    send_frame(0, -1);
    build_frame(MODE_GCM, 32'd3, -1, 6, 4);
    send_frame(19, -1);
    build_frame(MODE_GCM, 32'd3, -1, 6, 4);
    send_frame(13, -1);
    build_frame(MODE_GCM, 32'd3, -1, 6, 4);
    send_frame(25, -1);
    build_frame(MODE_GCM, 32'd3, -1, 6, 4);
    send_frame(16, -1);
    build_frame(MODE_GCM, 32'd2, -1, 1, 0);
    repeat (3) frame.push_back(byte_t'($urandom));
    send_frame(0, -1);
  endtask

  task automatic test_hash_capture();
    build_frame(MODE_GCM, 32'd90, 3, 4, 2);
    send_frame(0, -1);
    build_frame(8'h00, 32'd30, 9, NONCE_MAX, 0);
    send_frame(0, -1);
    build_frame(MODE_GCM, 32'd50, 20, 0, 0);
    frame[12 + 5] = 8'h00;
    send_frame(0, -1);
    build_frame(MODE_GCM, 32'd60, 0, 2, 0);
    for (int i = 0; i < KEY_LEN; i++) frame[12 + 30 + i] = HASH_KEY[i];
    send_frame(0, -1);
    build_frame(MODE_GCM, 32'd40, -1, 1, 0);
    for (int i = 0; i < WIN_LEN; i++) frame[12 + 5 + i] = HASH_KEY[i];
    frame[12 + 25] = "x";
    send_frame(0, -1);
    build_frame(MODE_GCM, 32'd70, 2, 3, 0);
    send_frame(52, -1);
  endtask

  task automatic test_drain_pause();
    build_frame(MODE_GCM, 32'd40, 5, 8, 3);
    send_frame(0, 30);
  endtask

  task automatic random_frame();
    int    pick;
    int    meta_n;
    int    key_at;
    int    nonce_n;
    int    tag_n;
    int    cut;
    int    pause_at;
    byte_t md;
    pick     = $urandom_range(0, 99);
    md       = $urandom_range(0, 1) ? MODE_GCM : byte_t'($urandom);
    meta_n   = ($urandom_range(0, 7) == 0) ? $urandom_range(29, 96) : $urandom_range(0, 28);
    key_at   = (meta_n >= KEY_LEN && $urandom_range(0, 1)) ? $urandom_range(0, meta_n - KEY_LEN)
                                                             : -1;
    nonce_n  = $urandom_range(0, NONCE_MAX);
    tag_n    = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 255) : $urandom_range(0, 12);
    cut      = 0;
    pause_at = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 20) : -1;
    build_frame(md, 32'(meta_n), key_at, nonce_n, tag_n);
    if (pick < 60) begin
      if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 3)) frame.push_back(byte_t'($urandom));
    end else if (pick < 78) begin
      cut = $urandom_range(1, frame.size());
    end else if (pick < 88) begin
      case ($urandom_range(0, 2))
        0: frame[$urandom_range(0, 3)] ^= byte_t'($urandom_range(1, 255));
        1: begin
          frame[12 + meta_n] = byte_t'($urandom_range(NONCE_MAX + 1, 255));
          cut = 12 + meta_n + $urandom_range(1, 4);
        end
        default: begin
          for (int i = 8; i < 12; i++) frame[i] = byte_t'($urandom);
          frame[11] = frame[11] | 8'h80;
          cut = 12 + $urandom_range(0, 3);
        end
      endcase
    end else begin
      frame.delete();
      repeat ($urandom_range(1, 24)) frame.push_back(byte_t'($urandom));
    end
    send_frame(cut, pause_at);
  endtask

  task automatic random_run(input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) random_frame();
  endtask

  task automatic test_random();
    random_run(140);
    settle();
    write_limit(13'($urandom_range(16, 64)));
    quiet = 1'b1;
    random_run(140);
    quiet = 1'b0;
    settle();
    write_limit(13'h1FFF);
    random_run(140);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    out_ready    = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = ADDR_MAX_META;
    pwdata       = '0;
    errors       = 0;
    bytes_sent   = 0;
    cycles       = 0;
    quiet        = 1'b0;
    meta_limit   = 13'(META_CAP);
    clear_parse();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_short_and_magic();
    test_metadata_limit();
    test_nonce_and_tag();
    test_hash_capture();
    test_drain_pause();
    test_random();
    settle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* encrypted_blob_header_parser_unit.f */
+incdir+hdl
hdl/ebhp_pkg.sv
hdl/ebhp_win_cell.sv
hdl/ebhp_res_queue.sv
hdl/encrypted_blob_header_parser_unit.sv
bench/encrypted_blob_header_parser_unit_tb.sv
